@@ src/pgw_pkg.sv @@
// Shared types, codes and helpers for the four-level page table walker.
package pgw_pkg;

	localparam int WALKERS  = 4;
	localparam int SLOT_W   = 2;
	localparam int VA_W     = 48;
	localparam int ADDR_W   = 64;
	localparam int LEVEL_W  = 2;
	localparam int CNT_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic FUNC_REQ  = 1'b0;
	localparam logic FUNC_FILL = 1'b1;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_FAULT = 2'd2;
	localparam logic [1:0] KIND_BUSY  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROOT      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTSTANDING = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

	localparam logic [ADDR_W-1:0] PAGE_MASK = ~64'hFFF;
	localparam logic [ADDR_W-1:0] LINE_MASK = ~64'h3F;

	typedef struct packed {
		logic              func;
		logic [VA_W-1:0]   virt_addr;
		logic [1:0]        fill_slot;
		logic [ADDR_W-1:0] entry_value;
	} walk_req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        walk_slot;
		logic [ADDR_W-1:0] address;
		logic [2:0]        entry_word;
		logic [VA_W-1:0]   orig_virt;
	} walk_rsp_t;

	// classified request passed from front to back
	typedef struct packed {
		logic              is_fill;
		logic              present;
		logic [1:0]        slot;
		logic [VA_W-1:0]   va;
		logic [ADDR_W-1:0] addr;
	} pgw_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pgw_qstat_t;

	function automatic logic [8:0] level_index(input logic [VA_W-1:0] va,
			input logic [LEVEL_W-1:0] level);
		logic [8:0] idx;
		case (level)
			2'd3:    idx = va[47:39];
			2'd2:    idx = va[38:30];
			2'd1:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
			input logic [VA_W-1:0] va, input logic [LEVEL_W-1:0] level);
		return base + {52'd0, level_index(va, level), 3'd0};
	endfunction

endpackage

@@ src/pgw_front.sv @@
// Front end: classifies requests, forms root entry or fill page address.
module pgw_front (
	input  pgw_pkg::walk_req_t            req,
	input  logic [pgw_pkg::ADDR_W-1:0]    table_root,
	output pgw_pkg::pgw_cmd_t             cmd
);
	import pgw_pkg::*;

	always_comb begin
		cmd.is_fill = (req.func == FUNC_FILL);
		cmd.present = req.entry_value[0];
		cmd.slot    = req.fill_slot;
		cmd.va      = req.virt_addr;
		if (req.func == FUNC_FILL) begin
			cmd.addr = req.entry_value & PAGE_MASK;
		end else begin
			cmd.addr = entry_addr(table_root, req.virt_addr, LEVEL_TOP);
		end
	end

endmodule

@@ src/pgw_queue.sv @@
// Two-entry request queue between front and back.
module pgw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pgw_pkg::pgw_cmd_t   wdata,
	input  logic                pop,
	output pgw_pkg::pgw_cmd_t   rdata,
	output pgw_pkg::pgw_qstat_t stat
);
	import pgw_pkg::*;

	pgw_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign stat.empty = (count_q == 2'd0);
	assign stat.full  = (count_q == 2'd2);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ src/pgw_back.sv @@
// Back end: walk slot state, one queued request per cycle, result register.
module pgw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pgw_pkg::pgw_cmd_t          cmd,
	input  pgw_pkg::pgw_qstat_t        qstat,
	input  logic [pgw_pkg::CNT_W-1:0]  max_outstanding,
	output logic                       pop,
	output logic                       rsp_valid,
	output pgw_pkg::walk_rsp_t         rsp
);
	import pgw_pkg::*;

	logic                slot_busy_q  [WALKERS];
	logic [VA_W-1:0]     slot_virt_q  [WALKERS];
	logic [LEVEL_W-1:0]  slot_level_q [WALKERS];

	logic                rsp_valid_q;
	walk_rsp_t           rsp_q;

	logic [CNT_W-1:0]    n_busy;
	logic                have_free;
	logic [SLOT_W-1:0]   free_idx;
	logic                alloc;
	logic                release_slot;
	logic                advance;
	logic                emit;
	walk_rsp_t           rsp_d;
	logic [VA_W-1:0]     fill_va;
	logic [LEVEL_W-1:0]  fill_level;
	logic [LEVEL_W-1:0]  next_level;
	logic [ADDR_W-1:0]   ea;

	always_comb begin
		n_busy    = '0;
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = 0; i < WALKERS; i++) begin
			n_busy = n_busy + CNT_W'(slot_busy_q[i]);
			if (!slot_busy_q[i] && !have_free) begin
				have_free = 1'b1;
				free_idx  = SLOT_W'(i);
			end
		end
	end

	assign fill_va    = slot_virt_q[cmd.slot];
	assign fill_level = slot_level_q[cmd.slot];
	assign next_level = fill_level - LEVEL_W'(1);
	assign ea         = entry_addr(cmd.addr, fill_va, next_level);
	assign pop        = !qstat.empty;

	always_comb begin
		alloc        = 1'b0;
		release_slot = 1'b0;
		advance      = 1'b0;
		emit         = 1'b0;
		rsp_d        = '0;
		if (!qstat.empty) begin
			if (!cmd.is_fill) begin
				emit            = 1'b1;
				rsp_d.orig_virt = cmd.va;
				if (!have_free || (max_outstanding != '0 && n_busy >= max_outstanding)) begin
					rsp_d.kind = KIND_BUSY;
				end else begin
					alloc            = 1'b1;
					rsp_d.kind       = KIND_READ;
					rsp_d.walk_slot  = free_idx;
					rsp_d.address    = cmd.addr & LINE_MASK;
					rsp_d.entry_word = cmd.addr[5:3];
				end
			end else if (32'(cmd.slot) < WALKERS && slot_busy_q[cmd.slot]) begin
				emit            = 1'b1;
				rsp_d.walk_slot = cmd.slot;
				rsp_d.orig_virt = fill_va;
				if (!cmd.present) begin
					release_slot = 1'b1;
					rsp_d.kind   = KIND_FAULT;
				end else if (fill_level == LEVEL_LEAF) begin
					release_slot  = 1'b1;
					rsp_d.kind    = KIND_DONE;
					rsp_d.address = cmd.addr | {52'd0, fill_va[11:0]};
				end else begin
					advance          = 1'b1;
					rsp_d.kind       = KIND_READ;
					rsp_d.address    = ea & LINE_MASK;
					rsp_d.entry_word = ea[5:3];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WALKERS; i++) begin
				slot_busy_q[i] <= 1'b0;
			end
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= emit;
			if (alloc) begin
				slot_busy_q[free_idx] <= 1'b1;
			end
			if (release_slot) begin
				slot_busy_q[cmd.slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (alloc) begin
			slot_virt_q[free_idx]  <= cmd.va;
			slot_level_q[free_idx] <= LEVEL_TOP;
		end
		if (advance) begin
			slot_level_q[cmd.slot] <= next_level;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/four_level_page_table_walker.sv @@
// Top level of the four-level page table walker: config registers, front, queue, back.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------
//  request   | start / busy           | request  (walk_req_t)
//  result    | result_valid (strobe)  | result   (walk_rsp_t)
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle; each request is held first in a queue entry, and its
// result is then held in the back end's result register.
// The back end drains one queued request per cycle, so busy stays low in use.
// Reset clears walk slots, queue and config; results cannot be stalled.
module four_level_page_table_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  pgw_pkg::walk_req_t              request,
	output logic                            result_valid,
	output pgw_pkg::walk_rsp_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pgw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pgw_pkg::ADDR_W-1:0]      cfg_data
);
	import pgw_pkg::*;

	logic [ADDR_W-1:0] table_root_q;
	logic [CNT_W-1:0]  max_outstanding_q;
	pgw_cmd_t          front_cmd;
	pgw_cmd_t          back_cmd;
	pgw_qstat_t        qstat;
	logic              pop;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign busy      = qstat.full;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q      <= '0;
			max_outstanding_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_ROOT:      table_root_q      <= cfg_data;
				CFG_MAX_OUTSTANDING: max_outstanding_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	pgw_front u_front (
		.req        (request),
		.table_root (table_root_q),
		.cmd        (front_cmd)
	);

	pgw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (back_cmd),
		.stat   (qstat)
	);

	pgw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (back_cmd),
		.qstat           (qstat),
		.max_outstanding (max_outstanding_q),
		.pop             (pop),
		.rsp_valid       (result_valid),
		.rsp             (result)
	);

	a_rsp_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(!qstat.empty))
		else $error("result without a queued request");

	a_read_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_READ |-> result.address[5:0] == 6'd0)
		else $error("line read not line aligned");

	a_busy_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_BUSY |->
			result.walk_slot == 2'd0 && result.address == '0 && result.entry_word == 3'd0)
		else $error("busy reply carries slot data");

	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.func == FUNC_REQ |-> ##2 result_valid)
		else $error("translation request not answered");

endmodule
